// ===== rtl/assert_macros.svh =====
// Assertion helpers, included by the window engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    `ASSERT_PROP(label, clk, rstn, !(expr), msg)

`endif

// ===== rtl/srsw_pkg.sv =====
package srsw_pkg;

    localparam int SEQ_BITS = 4;
    localparam int PAYLOAD_W = 64;
    localparam int DEFAULT_WINDOW = 8;
    localparam int DEFAULT_PAYLOAD_BITS = 64;

    // Conditional subtractions that reduce any sequence number below the smallest window.
    localparam int ACK_MOD_STEPS = (1 << SEQ_BITS) / 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = ((PAYLOAD_W + SEQ_BITS + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SEQ_BITS + PAYLOAD_W + 7) / 8) * 8;
    localparam int M_PAD_W = M_TDATA_W - SEQ_BITS - PAYLOAD_W;

    typedef logic [SEQ_BITS-1:0] seq_t;
    localparam seq_t SEQ_MAX = {SEQ_BITS{1'b1}};

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SEND = 2'd0;
    localparam kind_t KIND_ACK = 2'd1;
    localparam kind_t KIND_TIMEOUT = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t STATUS_SENT = 3'd0;
    localparam status_t STATUS_FULL = 3'd1;
    localparam status_t STATUS_ACK_TAKEN = 3'd2;
    localparam status_t STATUS_ACK_BAD = 3'd3;
    localparam status_t STATUS_ACK_OUTSIDE = 3'd4;
    localparam status_t STATUS_RESEND = 3'd5;
    localparam status_t STATUS_EMPTY = 3'd6;

    // One classified command on its way from the front end to the window engine.
    typedef struct packed {
        kind_t                kind;
        logic [PAYLOAD_W-1:0] payload;
        seq_t                 ack_seq;
        seq_t                 ack_res;
        logic                 ack_good;
    } cmd_t;

    // One result item as held in the output register.
    typedef struct packed {
        logic                 valid;
        status_t              status;
        seq_t                 seq;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } res_t;

endpackage

// ===== rtl/srsw_front.sv =====
module srsw_front import srsw_pkg::*; #(
    parameter int WINDOW = DEFAULT_WINDOW,
    parameter int PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam logic [PAYLOAD_W-1:0] PAY_MASK = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - PAYLOAD_BITS);

    seq_t ack_seq;
    int   res;

    assign ack_seq = s_axis_tdata[PAYLOAD_W+SEQ_BITS-1:PAYLOAD_W];
    assign s_axis_tready = !q_full;

    // Items of an unknown kind are taken and dropped here.
    assign q_push = s_axis_tvalid && !q_full &&
                    (s_axis_tuser == KIND_SEND || s_axis_tuser == KIND_ACK ||
                     s_axis_tuser == KIND_TIMEOUT);

    always_comb begin
        res = int'(ack_seq);
        for (int k = 0; k < ACK_MOD_STEPS; k++) begin
            if (res >= WINDOW) begin
                res = res - WINDOW;
            end
        end
        q_cmd.kind = s_axis_tuser;
        q_cmd.payload = s_axis_tdata[PAYLOAD_W-1:0] & PAY_MASK;
        q_cmd.ack_seq = ack_seq;
        q_cmd.ack_res = SEQ_BITS'(res);
        q_cmd.ack_good = s_axis_tdata[PAYLOAD_W+SEQ_BITS];
    end

endmodule

// ===== rtl/srsw_queue.sv =====
module srsw_queue import srsw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] count_next;

    assign empty = (count_reg == 2'd0);
    assign full = (count_reg == 2'd2);
    assign head = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/srsw_engine.sv =====
`include "assert_macros.svh"

module srsw_engine import srsw_pkg::*; #(
    parameter int WINDOW = DEFAULT_WINDOW,
    parameter int PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_empty,
    input  cmd_t q_head,
    output logic q_pop,
    input  logic m_ready,
    output res_t result
);

    localparam int SW = $clog2(WINDOW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLIDE,
        ST_SCAN
    } state_t;

    state_t            state_reg, state_next;
    logic [WINDOW-1:0] acked_reg, acked_next;
    seq_t              base_reg, base_next;
    seq_t              base_res_reg, base_res_next;
    seq_t              next_reg, next_next;
    seq_t              next_res_reg, next_res_next;
    seq_t              iter_reg, iter_next;
    seq_t              iter_res_reg, iter_res_next;
    logic [SW-1:0]     count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    seq_t              pend_seq_reg, pend_seq_next;
    res_t              out_reg, out_next;

    logic [PAYLOAD_BITS-1:0] payload_store_reg [WINDOW];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;
    logic                    mem_we;
    logic [SW-1:0]           mem_wr_idx;
    logic [PAYLOAD_BITS-1:0] mem_wr_data;
    logic                    mem_rd_en;
    logic [SW-1:0]           mem_rd_idx;

    logic out_free;
    logic in_window;
    logic full;
    int   next_plus;

    // Residue of the following sequence number, restarting at zero past WINDOW - 1 or at a wrap.
    function automatic seq_t res_succ(seq_t s, seq_t r);
        if (s == SEQ_MAX || int'(r) == WINDOW - 1) begin
            return '0;
        end
        return r + seq_t'(1);
    endfunction

    assign result = out_reg;
    assign out_free = !out_reg.valid || m_ready;

    always_comb begin
        next_plus = int'(next_res_reg) + 1;
        if (next_plus == WINDOW) begin
            next_plus = 0;
        end
        full = (next_plus == int'(base_res_reg));
        if (base_res_reg > next_res_reg) begin
            in_window = (q_head.ack_res >= base_res_reg) || (q_head.ack_res < next_res_reg);
        end else begin
            in_window = (q_head.ack_res >= base_res_reg) && (q_head.ack_res < next_res_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        acked_next = acked_reg;
        base_next = base_reg;
        base_res_next = base_res_reg;
        next_next = next_reg;
        next_res_next = next_res_reg;
        iter_next = iter_reg;
        iter_res_next = iter_res_reg;
        count_next = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next = pend_seq_reg;
        out_next = out_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_wr_idx = SW'(next_res_reg);
        mem_wr_data = PAYLOAD_BITS'(q_head.payload);
        mem_rd_en = 1'b0;
        mem_rd_idx = SW'(iter_res_reg);

        if (out_reg.valid && m_ready) begin
            out_next.valid = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    out_next.valid = 1'b0;
                    out_next.seq = '0;
                    out_next.payload = '0;
                    out_next.last = 1'b1;
                    case (q_head.kind)
                        KIND_SEND: begin
                            out_next.valid = 1'b1;
                            if (full) begin
                                out_next.status = STATUS_FULL;
                            end else begin
                                mem_we = 1'b1;
                                acked_next[SW'(next_res_reg)] = 1'b0;
                                out_next.status = STATUS_SENT;
                                out_next.seq = next_reg;
                                out_next.payload = q_head.payload;
                                next_next = next_reg + seq_t'(1);
                                next_res_next = res_succ(next_reg, next_res_reg);
                            end
                        end
                        KIND_ACK: begin
                            out_next.valid = 1'b1;
                            out_next.seq = q_head.ack_seq;
                            if (!q_head.ack_good) begin
                                out_next.status = STATUS_ACK_BAD;
                            end else if (!in_window) begin
                                out_next.status = STATUS_ACK_OUTSIDE;
                            end else begin
                                acked_next[SW'(q_head.ack_res)] = 1'b1;
                                out_next.status = STATUS_ACK_TAKEN;
                                state_next = ST_SLIDE;
                            end
                        end
                        KIND_TIMEOUT: begin
                            iter_next = base_reg;
                            iter_res_next = base_res_reg;
                            count_next = '0;
                            pend_valid_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SLIDE: begin
                if (acked_reg[SW'(base_res_reg)] && base_reg != next_reg) begin
                    base_next = base_reg + seq_t'(1);
                    base_res_next = res_succ(base_reg, base_res_reg);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (iter_reg == next_reg || int'(count_reg) == WINDOW - 1) begin
                    // The held resend is the final one; an empty pass reports a status.
                    if (out_free) begin
                        out_next.valid = 1'b1;
                        out_next.last = 1'b1;
                        if (pend_valid_reg) begin
                            out_next.status = STATUS_RESEND;
                            out_next.seq = pend_seq_reg;
                            out_next.payload = PAYLOAD_W'(rd_data_reg);
                        end else begin
                            out_next.status = STATUS_EMPTY;
                            out_next.seq = '0;
                            out_next.payload = '0;
                        end
                        pend_valid_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end else if (acked_reg[SW'(iter_res_reg)]) begin
                    iter_next = iter_reg + seq_t'(1);
                    iter_res_next = res_succ(iter_reg, iter_res_reg);
                end else if (!pend_valid_reg || out_free) begin
                    // A resend is held back until the next one is found, so its last flag is known.
                    if (pend_valid_reg) begin
                        out_next.valid = 1'b1;
                        out_next.status = STATUS_RESEND;
                        out_next.seq = pend_seq_reg;
                        out_next.payload = PAYLOAD_W'(rd_data_reg);
                        out_next.last = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_seq_next = iter_reg;
                    mem_rd_en = 1'b1;
                    count_next = count_reg + SW'(1);
                    iter_next = iter_reg + seq_t'(1);
                    iter_res_next = res_succ(iter_reg, iter_res_reg);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acked_reg <= '0;
            base_reg <= '0;
            base_res_reg <= '0;
            next_reg <= '0;
            next_res_reg <= '0;
            iter_reg <= '0;
            iter_res_reg <= '0;
            count_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_seq_reg <= '0;
            out_reg <= '0;
        end else begin
            state_reg <= state_next;
            acked_reg <= acked_next;
            base_reg <= base_next;
            base_res_reg <= base_res_next;
            next_reg <= next_next;
            next_res_reg <= next_res_next;
            iter_reg <= iter_next;
            iter_res_reg <= iter_res_next;
            count_reg <= count_next;
            pend_valid_reg <= pend_valid_next;
            pend_seq_reg <= pend_seq_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            payload_store_reg[mem_wr_idx] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= payload_store_reg[mem_rd_idx];
        end
    end

    `ASSERT_NEVER(a_next_res_range, aclk, aresetn, int'(next_res_reg) >= WINDOW, "next slot out of range")
    `ASSERT_PROP(a_slide_stops, aclk, aresetn, (state_reg == ST_SLIDE && base_reg == next_reg) |=> (state_reg == ST_IDLE), "base slid past next sequence")
    `ASSERT_NEVER(a_resend_cap, aclk, aresetn, int'(count_reg) > WINDOW - 1, "resend count above cap")
    `ASSERT_NEVER(a_pend_in_scan, aclk, aresetn, pend_valid_reg && state_reg != ST_SCAN, "held resend outside scan")

endmodule

// ===== rtl/selective_repeat_sender_window.sv =====
// Sender side of a selective-repeat ARQ window.
// Input stream (s_axis_*): tuser carries the kind (send, acknowledgement, timer expired);
// tdata carries the payload, the acknowledged sequence number and the checksum flag.
// Output stream (m_axis_*): tuser carries the status, tdata the sequence number and the
// payload of a sent or resent packet; tlast marks the final result of one input item.
// A classifying front end writes commands into a two-entry queue; the window engine
// drains it one command at a time, so the input keeps flowing while results wait.
// A send or an acknowledgement result passes through the queue and the output register,
// and sends or rejected acknowledgements can follow one per cycle while results are taken.
// An accepted acknowledgement then slides the base one entry per cycle until the base entry
// is unacknowledged or the base meets the next sequence number, before the next command
// starts. A timeout scans one window position per cycle unless a resend waits for the output
// register, and emits each resend as the following one is found. Items of an unknown kind
// are taken and cause nothing.
// Reset clears the acknowledged flags, the base and the next sequence number; the payload
// memory is not cleared and needs no sweep, so items are taken right after reset.
// When the receiver holds m_axis_tready low, the result stays in the output register,
// the engine halts at its next result, and the input stops once the queue is full.
module selective_repeat_sender_window import srsw_pkg::*; #(
    parameter int WINDOW = DEFAULT_WINDOW,
    parameter int PAYLOAD_BITS = DEFAULT_PAYLOAD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // payload[63:0], ack_seq[67:64], ack_checksum_good[68], zero[71:69]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // seq[3:0], tx_payload[67:4], zero[71:68]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;
    res_t result;

    srsw_front #(
        .WINDOW(WINDOW),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .q_full(q_full),
        .q_push(q_push),
        .q_cmd(q_cmd)
    );

    srsw_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_cmd(q_cmd),
        .pop(q_pop),
        .head(q_head),
        .empty(q_empty),
        .full(q_full)
    );

    srsw_engine #(
        .WINDOW(WINDOW),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_head(q_head),
        .q_pop(q_pop),
        .m_ready(m_axis_tready),
        .result(result)
    );

    assign m_axis_tvalid = result.valid;
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, result.payload, result.seq};
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.last;

endmodule

// ===== bench/tb.sv =====
module tb import srsw_pkg::*; ();

    localparam int WIN = DEFAULT_WINDOW;
    localparam int CLK_PERIOD = 12;
    localparam int SEQ_SPAN = 1 << SEQ_BITS;
    localparam int RAND_ITEMS = 105;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam kind_t KIND_NONE = 2'd3;

    typedef struct packed {
        status_t              status;
        seq_t                 seq;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } tx_item_t;

    typedef struct {
        kind_t                kind;
        logic [PAYLOAD_W-1:0] payload;
        seq_t                 ack_seq;
        logic                 good;
        logic                 typed;
        status_t              exp_status;
        seq_t                 exp_seq;
        logic [PAYLOAD_W-1:0] exp_payload;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    // Shadow copy of the sender window.
    logic [PAYLOAD_W-1:0] sent_payload [WIN];
    logic                 acked [WIN];
    seq_t                 win_base;
    seq_t                 win_next;

    tx_item_t step_res [$];
    tx_item_t tx_expect_q [$];
    int       fail_count = 0;
    int       results_seen = 0;
    logic     sender_calm = 1'b0;

    selective_repeat_sender_window #(
        .WINDOW(WIN),
        .PAYLOAD_BITS(DEFAULT_PAYLOAD_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // The window test compares residues, so an alias one full window away
    // lands in the same slot and is taken.
    function automatic logic ack_in_window(seq_t a);
        int b = win_base % WIN;
        int s = win_next % WIN;
        int r = a % WIN;
        if (b > s)
            return (r >= b) || (r < s);
        return (r >= b) && (r < s);
    endfunction

    // Applies one input item to the shadow window and leaves its results in step_res.
    function automatic void window_event(kind_t k, logic [PAYLOAD_W-1:0] pay, seq_t a,
                                         logic good);
        tx_item_t r;
        seq_t     i;
        int       n;
        int       steps;
        step_res.delete();
        r = '0;
        case (k)
            KIND_SEND: begin
                r.last = 1'b1;
                if (((win_next + 1) % WIN) == (win_base % WIN)) begin
                    r.status = STATUS_FULL;
                end else begin
                    acked[win_next % WIN] = 1'b0;
                    sent_payload[win_next % WIN] = pay;
                    r.status = STATUS_SENT;
                    r.seq = win_next;
                    r.payload = pay;
                    win_next = win_next + 1'b1;
                end
                step_res.push_back(r);
            end
            KIND_ACK: begin
                r.seq = a;
                r.last = 1'b1;
                if (!good) begin
                    r.status = STATUS_ACK_BAD;
                end else if (!ack_in_window(a)) begin
                    r.status = STATUS_ACK_OUTSIDE;
                end else begin
                    acked[a % WIN] = 1'b1;
                    steps = 0;
                    while (acked[win_base % WIN] && win_base != win_next
                           && steps < SEQ_SPAN) begin
                        win_base = win_base + 1'b1;
                        steps++;
                    end
                    r.status = STATUS_ACK_TAKEN;
                end
                step_res.push_back(r);
            end
            KIND_TIMEOUT: begin
                i = win_base;
                n = 0;
                steps = 0;
                while (i != win_next && steps < SEQ_SPAN && n < WIN - 1) begin
                    if (!acked[i % WIN]) begin
                        r.status = STATUS_RESEND;
                        r.seq = i;
                        r.payload = sent_payload[i % WIN];
                        r.last = 1'b0;
                        step_res.push_back(r);
                        n++;
                    end
                    i = i + 1'b1;
                    steps++;
                end
                if (n == 0) begin
                    r = '0;
                    r.status = STATUS_EMPTY;
                    r.last = 1'b1;
                    step_res.push_back(r);
                end else begin
                    r = step_res.pop_back();
                    r.last = 1'b1;
                    step_res.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one item, starting right after a falling edge, and returns after the
    // falling edge that follows its transfer.
    task automatic offer(kind_t k, logic [PAYLOAD_W-1:0] pay, seq_t a, logic good,
                         logic typed, tx_item_t typed_res);
        while (!sender_calm && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= k;
        s_axis_tdata <= S_TDATA_W'({good, a, pay});
        do @(posedge aclk); while (!s_axis_tready);
        window_event(k, pay, a, good);
        if (typed)
            tx_expect_q.push_back(typed_res);
        else
            foreach (step_res[j]) tx_expect_q.push_back(step_res[j]);
        @(negedge aclk);
    endtask

    // Result checker.
    always @(posedge aclk) begin : check_results
        tx_item_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (tx_expect_q.size() == 0) begin
                $error("unexpected result: status %0d seq %0d", m_axis_tuser,
                       m_axis_tdata[SEQ_BITS-1:0]);
                fail_count++;
            end else begin
                want = tx_expect_q.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[SEQ_BITS-1:0] !== want.seq) begin
                    $error("seq: expected %0d, got %0d", want.seq,
                           m_axis_tdata[SEQ_BITS-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[SEQ_BITS +: PAYLOAD_W] !== want.payload) begin
                    $error("tx_payload: expected %h, got %h", want.payload,
                           m_axis_tdata[SEQ_BITS +: PAYLOAD_W]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Receiver side: random back-pressure, one long hold-off and one calm stretch.
    initial begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 60) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (results_seen >= 120 && results_seen < 200) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 31);
            end
        end
    end

    initial begin : sender
        stim_row_t            plan [$];
        tx_item_t             typed_res;
        logic [PAYLOAD_W-1:0] pay;
        seq_t                 a;
        int                   sel;
        int                   outstanding;
        int                   done_items;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_SEND;
        aresetn = 1'b0;
        win_base = '0;
        win_next = '0;
        foreach (acked[j]) begin
            acked[j] = 1'b0;
            sent_payload[j] = '0;
        end

        plan = '{
            '{KIND_TIMEOUT, 64'h0, 4'd0, 1'b1, 1'b1, STATUS_EMPTY, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd0, 1'b1, 1'b1, STATUS_ACK_OUTSIDE, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd15, 1'b0, 1'b1, STATUS_ACK_BAD, 4'd15, 64'h0},
            '{KIND_SEND, 64'h0, 4'd0, 1'b0, 1'b1, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_SEND, {64{1'b1}}, 4'd15, 1'b1, 1'b1, STATUS_SENT, 4'd1, {64{1'b1}}},
            '{KIND_SEND, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0, 1'b0, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_SEND, 64'h8000_0000_0000_0001, 4'd0, 1'b0, 1'b0, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_SEND, 64'h5555_5555_5555_5555, 4'd0, 1'b0, 1'b0, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 1'b0, 1'b0, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_SEND, 64'hDEAD_BEEF_0000_FFFF, 4'd0, 1'b0, 1'b0, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_SEND, 64'h1234, 4'd0, 1'b0, 1'b1, STATUS_FULL, 4'd0, 64'h0},
            '{KIND_TIMEOUT, 64'h0, 4'd0, 1'b0, 1'b0, STATUS_RESEND, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd3, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd0, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd1, 1'b0, 1'b0, STATUS_ACK_BAD, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd1, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd2, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_TIMEOUT, 64'h0, 4'd0, 1'b0, 1'b0, STATUS_RESEND, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd12, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_NONE, 64'hFFFF_0000_FFFF_0000, 4'd9, 1'b1, 1'b0, STATUS_SENT, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd15, 1'b1, 1'b0, STATUS_ACK_OUTSIDE, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd5, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_ACK, 64'h0, 4'd6, 1'b1, 1'b0, STATUS_ACK_TAKEN, 4'd0, 64'h0},
            '{KIND_TIMEOUT, 64'h0, 4'd0, 1'b0, 1'b0, STATUS_EMPTY, 4'd0, 64'h0},
            '{KIND_SEND, 64'h0F0F_0F0F_0F0F_0F0F, 4'd0, 1'b0, 1'b0, STATUS_SENT, 4'd0, 64'h0}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[r]) begin
            typed_res = '0;
            typed_res.status = plan[r].exp_status;
            typed_res.seq = plan[r].exp_seq;
            typed_res.payload = plan[r].exp_payload;
            typed_res.last = 1'b1;
            offer(plan[r].kind, plan[r].payload, plan[r].ack_seq, plan[r].good,
                  plan[r].typed, typed_res);
        end

        // Random part: mostly sends and acknowledgements aimed inside the window,
        // with bad checksums, stray acknowledgements, timeouts and unknown kinds mixed in.
        typed_res = '0;
        done_items = 0;
        while (done_items < RAND_ITEMS) begin
            sender_calm = (done_items >= 40 && done_items < 75);
            sel = $urandom_range(99);
            pay = {$urandom, $urandom};
            a = seq_t'($urandom_range(SEQ_SPAN - 1));
            outstanding = int'(seq_t'(win_next - win_base));
            if (sel < 45) begin
                offer(KIND_SEND, pay, a, 1'($urandom_range(1)), 1'b0, typed_res);
            end else if (sel < 75) begin
                if (outstanding > 0 && $urandom_range(99) < 75)
                    a = win_base + seq_t'($urandom_range(outstanding - 1));
                offer(KIND_ACK, pay, a, 1'b1, 1'b0, typed_res);
            end else if (sel < 83) begin
                offer(KIND_ACK, pay, a, 1'b0, 1'b0, typed_res);
            end else if (sel < 95) begin
                offer(KIND_TIMEOUT, pay, a, 1'($urandom_range(1)), 1'b0, typed_res);
            end else begin
                offer(KIND_NONE, pay, a, 1'($urandom_range(1)), 1'b0, typed_res);
                done_items--;
            end
            done_items++;
        end
        s_axis_tvalid <= 1'b0;

        while (tx_expect_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && tx_expect_q.size() == 0) begin
            $display("** selective_repeat_sender_window: PASSED **");
        end else begin
            $display("** selective_repeat_sender_window: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 200000);
        $display("** selective_repeat_sender_window: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srsw_pkg.sv
rtl/srsw_front.sv
rtl/srsw_queue.sv
rtl/srsw_engine.sv
rtl/selective_repeat_sender_window.sv
bench/tb.sv
